FILE: hw/rtl/wfs_pkg.sv
`default_nettype none

package wfs_pkg;

  // Field widths of the stream payloads.
  localparam int RAND_W      = 32;
  localparam int TIME_W      = 32;
  localparam int KIND_W      = 3;
  localparam int CNT_OUT_W   = 32;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 104;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PCT_W      = 7;
  localparam int MASK_W     = 8;

  typedef logic [CFG_ADDR_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INJECT_ENABLE = 3'd0;
  localparam cfg_idx_t CFG_INTERVAL_LOW  = 3'd1;
  localparam cfg_idx_t CFG_INTERVAL_HIGH = 3'd2;
  localparam cfg_idx_t CFG_FIRE_PERCENT  = 3'd3;
  localparam cfg_idx_t CFG_TYPE_MASK     = 3'd4;
  localparam cfg_idx_t CFG_TYPE_WEIGHTS  = 3'd5;

  localparam logic [RAND_W-1:0]     INTERVAL_LOW_RST  = 32'd2500;
  localparam logic [RAND_W-1:0]     INTERVAL_HIGH_RST = 32'd15000;
  localparam logic [PCT_W-1:0]      FIRE_PERCENT_RST  = 7'd10;
  localparam logic [MASK_W-1:0]     TYPE_MASK_RST     = 8'hFF;
  localparam logic [CFG_DATA_W-1:0] TYPE_WEIGHTS_RST  = 64'h0A0A_0A0A_0A0A_0A0A;

  // Byte lane of each weight inside type_weights.
  localparam int WEIGHT_LANE = 8;

  localparam int PERCENT_BASE = 100;

  // x / 100 equals (x * PCT_RECIP) >> PCT_SHIFT for every 32-bit x.
  localparam logic [RAND_W-1:0] PCT_RECIP = 32'h51EB_851F;
  localparam int PCT_SHIFT = 37;
  localparam int PCT_Q_W   = 2*RAND_W - PCT_SHIFT;

  // The divider handles spans up to 2^32, so operands carry one extra bit.
  localparam int DIV_W   = 33;
  localparam int DIV_CNT_W = 5;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_TICK = 2'd0;
  localparam op_t OP_ARM  = 2'd1;
  localparam op_t OP_TRIG = 2'd2;

  typedef enum logic {
    DIV_PICK  = 1'b0,
    DIV_DELAY = 1'b1
  } div_sel_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_GATE   = 6'b000100,
    S_PICK   = 6'b001000,
    S_DELAY  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     disarm;
    logic     dec;
    logic     div_start;
    div_sel_t div_sel;
    logic     fire;
    logic     load;
    logic     out_load;
  } wfs_cmd_t;

  typedef struct packed {
    op_t  op;
    logic enable;
    logic armed;
    logic rem_gt1;
    logic gate_hit;
    logic div_done;
  } wfs_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wfs_div.sv
`default_nettype none

module wfs_div import wfs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAND_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]  divisor,
  output logic                   done,
  output logic [DIV_W-1:0]       rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [RAND_W-1:0]    dvd_r, dvd_nxt;
  logic [DIV_W:0]       shifted;

  // Restoring division, one quotient bit per cycle; only the remainder is kept.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dvd_nxt  = dvd_r;
    shifted  = {rem_r, dvd_r[RAND_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_W'(shifted - {1'b0, dvs_r});
      end else begin
        rem_nxt = shifted[DIV_W-1:0];
      end
      dvd_nxt = {dvd_r[RAND_W-2:0], 1'b0};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(RAND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");

endmodule

`default_nettype wire

FILE: hw/rtl/wfs_dpath.sv
`default_nettype none

module wfs_dpath import wfs_pkg::*; #(
  parameter int NUM_TYPES   = 8,
  parameter int WEIGHT_BITS = 8,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [OP_W-1:0]        in_tuser,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire wfs_cmd_t               cmd,
  output wfs_status_t                 status
);

  localparam int IDX_W = $clog2(NUM_TYPES);
  localparam int TOT_W = WEIGHT_BITS + IDX_W;

  // Configuration registers.
  logic                  enable_r;
  logic [RAND_W-1:0]     ilow_r;
  logic [RAND_W-1:0]     ihigh_r;
  logic [PCT_W-1:0]      pct_r;
  logic [MASK_W-1:0]     mask_r;
  logic [CFG_DATA_W-1:0] weights_r;

  // Latched item.
  op_t               op_r;
  logic [RAND_W-1:0] gate_r, pick_r, delay_r;
  logic [KIND_W-1:0] query_r;

  // Percent gate: quotient taken at accept, remainder in the cycle after.
  logic [2*RAND_W-1:0] gate_prod;
  logic [PCT_Q_W-1:0]  gate_q_r;
  logic [RAND_W-1:0]   gate_mul;
  logic [PCT_W-1:0]    gate_rem_r;

  // Scheduler state.
  logic                  armed_r, armed_nxt;
  logic [RAND_W-1:0]     remaining_r, remaining_nxt;
  logic [TIME_W-1:0]     tick_now_r;
  logic [COUNT_BITS-1:0] fired_total_r;
  logic [COUNT_BITS-1:0] type_cnt_r [NUM_TYPES];
  logic [IDX_W-1:0]      last_kind_r;
  logic [TIME_W-1:0]     last_time_r;
  logic                  fired_r;
  logic [IDX_W-1:0]      kind_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  acc;
  logic [TOT_W-1:0]  pick_val;
  logic              found;
  logic [IDX_W-1:0]  kind_sel;
  logic [DIV_W-1:0]  span;
  logic [RAND_W-1:0] div_dvd;
  logic [DIV_W-1:0]  div_dvs;
  logic              div_done;
  logic [DIV_W-1:0]  div_rem;
  logic [CNT_OUT_W-1:0] query_cnt;

  // Sum of the enabled weights.
  always_comb begin
    total = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (mask_r[i]) begin
        total = total + TOT_W'(weights_r[WEIGHT_LANE*i +: WEIGHT_BITS]);
      end
    end
  end

  // First enabled type whose running weight sum passes the draw.
  always_comb begin
    acc      = '0;
    found    = 1'b0;
    kind_sel = '0;
    pick_val = div_rem[TOT_W-1:0];
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (mask_r[i]) begin
        acc = acc + TOT_W'(weights_r[WEIGHT_LANE*i +: WEIGHT_BITS]);
        if (!found && (pick_val < acc)) begin
          kind_sel = IDX_W'(i);
          found    = 1'b1;
        end
      end
    end
    if (total == '0) begin
      kind_sel = '0;
    end
  end

  always_comb begin
    if (ihigh_r < ilow_r) begin
      span = DIV_W'(1);
    end else begin
      span = DIV_W'(ihigh_r) - DIV_W'(ilow_r) + DIV_W'(1);
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_PICK: begin
        div_dvd = pick_r;
        div_dvs = DIV_W'(total);
      end
      DIV_DELAY: begin
        div_dvd = delay_r;
        div_dvs = span;
      end
      default: begin
        div_dvd = pick_r;
        div_dvs = DIV_W'(total);
      end
    endcase
  end

  wfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign gate_prod = (2*RAND_W)'(in_tdata[RAND_W-1:0]) * (2*RAND_W)'(PCT_RECIP);
  assign gate_mul  = RAND_W'(gate_q_r) * RAND_W'(PERCENT_BASE);

  always_ff @(posedge clk) begin
    gate_rem_r <= PCT_W'(gate_r - gate_mul);
  end

  always_comb begin
    armed_nxt     = armed_r;
    remaining_nxt = remaining_r;
    if (cmd.dec) begin
      remaining_nxt = remaining_r - RAND_W'(1);
    end
    if (cmd.load) begin
      armed_nxt     = 1'b1;
      remaining_nxt = ilow_r + div_rem[RAND_W-1:0];
    end
    if (cmd.disarm) begin
      armed_nxt = 1'b0;
    end
    if (cfg_we && (cfg_addr == CFG_INJECT_ENABLE) && !cfg_wdata[0]) begin
      armed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      ilow_r    <= INTERVAL_LOW_RST;
      ihigh_r   <= INTERVAL_HIGH_RST;
      pct_r     <= FIRE_PERCENT_RST;
      mask_r    <= TYPE_MASK_RST;
      weights_r <= TYPE_WEIGHTS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_INJECT_ENABLE: enable_r  <= cfg_wdata[0];
        CFG_INTERVAL_LOW:  ilow_r    <= cfg_wdata[RAND_W-1:0];
        CFG_INTERVAL_HIGH: ihigh_r   <= cfg_wdata[RAND_W-1:0];
        CFG_FIRE_PERCENT:  pct_r     <= cfg_wdata[PCT_W-1:0];
        CFG_TYPE_MASK:     mask_r    <= cfg_wdata[MASK_W-1:0];
        CFG_TYPE_WEIGHTS:  weights_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      remaining_r   <= '0;
      tick_now_r    <= '0;
      fired_total_r <= '0;
      last_kind_r   <= '0;
      last_time_r   <= '0;
      fired_r       <= 1'b0;
      kind_r        <= '0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        type_cnt_r[i] <= '0;
      end
    end else begin
      armed_r     <= armed_nxt;
      remaining_r <= remaining_nxt;
      if (cmd.accept) begin
        fired_r <= 1'b0;
        kind_r  <= '0;
        if (in_tuser == OP_TICK) begin
          tick_now_r <= tick_now_r + TIME_W'(1);
        end
      end
      if (cmd.fire) begin
        fired_r              <= 1'b1;
        kind_r               <= kind_sel;
        fired_total_r        <= fired_total_r + COUNT_BITS'(1);
        type_cnt_r[kind_sel] <= type_cnt_r[kind_sel] + COUNT_BITS'(1);
        last_kind_r          <= kind_sel;
        last_time_r          <= tick_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_tuser;
      gate_r   <= in_tdata[RAND_W-1:0];
      gate_q_r <= gate_prod[2*RAND_W-1:PCT_SHIFT];
      pick_r   <= in_tdata[2*RAND_W-1:RAND_W];
      delay_r  <= in_tdata[3*RAND_W-1:2*RAND_W];
      query_r  <= in_tdata[3*RAND_W+KIND_W-1:3*RAND_W];
    end
  end

  always_comb begin
    if ((KIND_W+1)'(query_r) < (KIND_W+1)'(NUM_TYPES)) begin
      query_cnt = CNT_OUT_W'(type_cnt_r[query_r[IDX_W-1:0]]);
    end else begin
      query_cnt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {armed_r,
                     last_time_r,
                     KIND_W'(last_kind_r),
                     query_cnt,
                     CNT_OUT_W'(fired_total_r),
                     KIND_W'(kind_r),
                     fired_r};
    end
  end

  assign out_tdata = out_data_r;

  assign status.op       = op_r;
  assign status.enable   = enable_r;
  assign status.armed    = armed_r;
  assign status.rem_gt1  = (remaining_r > RAND_W'(1));
  assign status.gate_hit = (gate_rem_r < pct_r);
  assign status.div_done = div_done;

endmodule

`default_nettype wire

FILE: hw/rtl/wfs_ctrl.sv
`default_nettype none

module wfs_ctrl import wfs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire wfs_status_t status,
  output wfs_cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_sel   = DIV_PICK;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        case (status.op)
          OP_TICK: begin
            if (!status.enable) begin
              cmd.disarm = 1'b1;
            end else if (status.armed && status.rem_gt1) begin
              cmd.dec = 1'b1;
            end else if (status.armed) begin
              state_nxt = S_GATE;
            end
          end
          OP_ARM: begin
            if (status.enable) begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = DIV_DELAY;
              state_nxt     = S_DELAY;
            end else begin
              cmd.disarm = 1'b1;
            end
          end
          OP_TRIG: begin
            if (status.enable) begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = DIV_PICK;
              state_nxt     = S_PICK;
            end
          end
          default: begin
          end
        endcase
      end
      // The percent remainder is ready in the cycle after the decision.
      S_GATE: begin
        cmd.div_start = 1'b1;
        if (status.gate_hit) begin
          cmd.div_sel = DIV_PICK;
          state_nxt   = S_PICK;
        end else begin
          cmd.div_sel = DIV_DELAY;
          state_nxt   = S_DELAY;
        end
      end
      S_PICK: begin
        if (status.div_done) begin
          cmd.fire = 1'b1;
          // An expired countdown reloads after the fault; a trigger does not.
          if (status.op == OP_TICK) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_DELAY;
            state_nxt     = S_DELAY;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DELAY: begin
        if (status.div_done) begin
          cmd.load  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r && (state_r == S_IDLE))
    else $error("result load did not complete the item");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == S_PICK || state_r == S_DELAY))
    else $error("divider finished outside a waiting state");

endmodule

`default_nettype wire

FILE: hw/rtl/weighted_fault_scheduler.sv
`default_nettype none

// Channel   Direction  Beat fields (lowest bit first)
// in        slave      tuser: op; tdata: rand_gate, rand_pick, rand_delay, query_type
// out       master     tdata: fired, fault_kind, total_fired, query_count,
//                      recent_kind, recent_time, is_armed
// cfg       write      index 0..5: inject_enable, interval_low, interval_high,
//                      fire_percent, type_mask, type_weights
//
// One item at a time: an item takes 0 to 2 remainders on the shared one-bit-per-cycle
// divider (type draw, next countdown), and an expired countdown also goes through the
// percent gate first. The result loads in the cycle before the next beat can be
// taken. Reset (rst_n low, synchronous) clears all counters and state and restores
// the register defaults. A result waits in the output register; the next beat is
// taken meanwhile, and its own result is held until the waiting one is taken.
module weighted_fault_scheduler import wfs_pkg::*; #(
  parameter int NUM_TYPES   = 8,
  parameter int WEIGHT_BITS = 8,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // rand_gate[31:0], rand_pick[63:32], rand_delay[95:64], query_type[98:96]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  wire logic [OP_W-1:0]        in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // fired[0], fault_kind[3:1], total_fired[35:4], query_count[67:36],
  // recent_kind[70:68], recent_time[102:71], is_armed[103]
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  wfs_cmd_t    cmd;
  wfs_status_t status;

  wfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  wfs_dpath #(
    .NUM_TYPES   (NUM_TYPES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
